FILE: rtl/core/tlb_sr_pkg.sv
// Package for the TLB slot replacement block.
// Operation codes, sequencer states and the stored entry layout; no dependencies.
`timescale 1ns / 1ps

package tlb_sr_pkg;

	localparam logic [1:0] OP_INSERT    = 2'd0;
	localparam logic [1:0] OP_INV_FRAME = 2'd1;
	localparam logic [1:0] OP_INV_ALL   = 2'd2;

	localparam int PAGE_W  = 20;
	localparam int STAMP_W = 32;
	localparam int SLOT_W  = 6;
	localparam int COUNT_W = 7;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_LAST,
		S_FIN
	} state_t;

	typedef struct packed {
		logic [PAGE_W-1:0]  vpage;
		logic [PAGE_W-1:0]  frame;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

endpackage

FILE: rtl/core/tlb_sr_if.sv
// Request and response channel interfaces of the TLB slot replacement block.
// Depends on tlb_sr_pkg for field widths.
`timescale 1ns / 1ps

interface tlb_sr_req_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        operation;
	logic [tlb_sr_pkg::PAGE_W-1:0]     virtual_page;
	logic [tlb_sr_pkg::PAGE_W-1:0]     physical_frame;

	modport source (output valid, output operation, output virtual_page,
		output physical_frame, input ready);
	modport sink (input valid, input operation, input virtual_page,
		input physical_frame, output ready);
endinterface

interface tlb_sr_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [tlb_sr_pkg::SLOT_W-1:0]     slot;
	logic                              evicted;
	logic [tlb_sr_pkg::COUNT_W-1:0]    cleared_count;

	modport source (output valid, output slot, output evicted, output cleared_count,
		input ready);
	modport sink (input valid, input slot, input evicted, input cleared_count,
		output ready);
endinterface

FILE: rtl/core/tlb_slot_replacement.sv
// Translation table with oldest-stamp replacement, top level.
// Depends on tlb_sr_pkg and the channel interfaces in tlb_sr_if.
//
// Usage:
//   req carries one request (operation, virtual_page, physical_frame); rsp
//   returns exactly one response (slot, evicted, cleared_count) per request.
//   Insert, invalidate-by-frame and invalidate-all walk the whole table, one
//   entry per cycle through the single read port of the entry memory, and
//   then pass through the last and finish states before rsp.valid rises. An
//   unused operation code skips the walk and goes straight to the finish state.
//   One request is in work at a time; req.ready is high while idle, and a
//   new request is taken while the previous response still waits on rsp.
//   If rsp stalls, the finished request holds until the response register
//   frees; an insert writes the table only then, while invalidations clear
//   valid bits during the walk.
//   Reset clears all valid bits and the stamp counter at once; the memory
//   needs no clearing since an invalid entry is never used for its contents.
`timescale 1ns / 1ps

module tlb_slot_replacement #(
	parameter int ENTRIES = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	tlb_sr_req_if.sink    req,
	tlb_sr_rsp_if.source  rsp
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);

	tlb_sr_pkg::state_t state_q, state_d;

	logic [IW-1:0]                     cnt_q;
	logic [1:0]                        op_q;
	logic [tlb_sr_pkg::PAGE_W-1:0]     vpage_q;
	logic [tlb_sr_pkg::PAGE_W-1:0]     frame_q;
	logic [tlb_sr_pkg::STAMP_W-1:0]    stamp_q;
	logic [ENTRIES-1:0]                valid_q;

	logic                              rd_s1;
	logic [IW-1:0]                     idx_s1;
	tlb_sr_pkg::entry_t                rdata_s1;

	logic                              found_q;
	logic [IW-1:0]                     first_q;
	logic [tlb_sr_pkg::STAMP_W-1:0]    min_q;
	logic [IW-1:0]                     min_idx_q;
	logic [CW-1:0]                     count_q;

	logic                              rsp_valid_q;
	logic [tlb_sr_pkg::SLOT_W-1:0]     slot_q;
	logic                              evicted_q;
	logic [tlb_sr_pkg::COUNT_W-1:0]    cleared_q;

	tlb_sr_pkg::entry_t mem [ENTRIES];

	logic           accept, issue, fin_go, mem_we, cur_valid, hit;
	logic [IW-1:0]  wr_idx;
	tlb_sr_pkg::entry_t wdata;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tlb_sr_pkg::S_IDLE: begin
				if (accept) begin
					if (req.operation == tlb_sr_pkg::OP_INSERT ||
							req.operation == tlb_sr_pkg::OP_INV_FRAME ||
							req.operation == tlb_sr_pkg::OP_INV_ALL)
						state_d = tlb_sr_pkg::S_WALK;
					else
						state_d = tlb_sr_pkg::S_FIN;
				end
			end
			tlb_sr_pkg::S_WALK: begin
				if (cnt_q == IW'(ENTRIES - 1))
					state_d = tlb_sr_pkg::S_LAST;
			end
			tlb_sr_pkg::S_LAST: state_d = tlb_sr_pkg::S_FIN;
			tlb_sr_pkg::S_FIN: begin
				if (fin_go)
					state_d = tlb_sr_pkg::S_IDLE;
			end
			default: state_d = tlb_sr_pkg::S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		req.ready = (state_q == tlb_sr_pkg::S_IDLE);
		issue     = (state_q == tlb_sr_pkg::S_WALK);
		fin_go    = (state_q == tlb_sr_pkg::S_FIN) && (!rsp_valid_q || rsp.ready);
	end

	assign accept = req.valid && req.ready;
	assign mem_we = fin_go && (op_q == tlb_sr_pkg::OP_INSERT);
	assign wr_idx = found_q ? first_q : min_idx_q;

	always_comb begin
		wdata.vpage = vpage_q;
		wdata.frame = frame_q;
		wdata.stamp = stamp_q + 1'b1;
	end

	assign cur_valid = valid_q[idx_s1];
	assign hit = cur_valid && (rdata_s1.frame == frame_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tlb_sr_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// entry memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[wr_idx] <= wdata;
		rdata_s1 <= mem[cnt_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= issue;
			if (accept)
				cnt_q <= '0;
			else if (issue)
				cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		if (accept) begin
			op_q    <= req.operation;
			vpage_q <= req.virtual_page;
			frame_q <= req.physical_frame;
		end
	end

	// walk accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			count_q <= '0;
		end else if (accept) begin
			found_q <= 1'b0;
			count_q <= '0;
		end else if (rd_s1) begin
			case (op_q)
				tlb_sr_pkg::OP_INSERT: begin
					if (!cur_valid)
						found_q <= 1'b1;
				end
				tlb_sr_pkg::OP_INV_FRAME: begin
					if (hit)
						count_q <= count_q + 1'b1;
				end
				tlb_sr_pkg::OP_INV_ALL: begin
					if (cur_valid)
						count_q <= count_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rd_s1 && op_q == tlb_sr_pkg::OP_INSERT) begin
			if (!cur_valid && !found_q)
				first_q <= idx_s1;
			// ties go to the higher index
			if (idx_s1 == '0 || rdata_s1.stamp <= min_q) begin
				min_q     <= rdata_s1.stamp;
				min_idx_q <= idx_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			stamp_q <= '0;
		end else begin
			if (rd_s1 && ((op_q == tlb_sr_pkg::OP_INV_FRAME && hit) ||
					op_q == tlb_sr_pkg::OP_INV_ALL))
				valid_q[idx_s1] <= 1'b0;
			if (mem_we) begin
				valid_q[wr_idx] <= 1'b1;
				stamp_q         <= stamp_q + 1'b1;
			end
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fin_go) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			if (op_q == tlb_sr_pkg::OP_INSERT) begin
				slot_q    <= tlb_sr_pkg::SLOT_W'(wr_idx);
				evicted_q <= !found_q;
			end else begin
				slot_q    <= '0;
				evicted_q <= 1'b0;
			end
			cleared_q <= tlb_sr_pkg::COUNT_W'(count_q);
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.slot          = slot_q;
	assign rsp.evicted       = evicted_q;
	assign rsp.cleared_count = cleared_q;

	a_stamp_step: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> stamp_q == $past(stamp_q) + 1'b1)
		else $error("stamp counter did not advance on insert");

	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && !found_q) |-> (&valid_q))
		else $error("eviction with a free entry present");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |-> count_q <= CW'(ENTRIES))
		else $error("cleared count exceeds table size");

	a_inv_all_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_go && op_q == tlb_sr_pkg::OP_INV_ALL) |=> valid_q == '0)
		else $error("table not empty after invalidate-all");

endmodule
